@@ rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
package fpa_pkg;

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_DIV  = 4'd3,
        FN_MIN  = 4'd4,
        FN_MAX  = 4'd5,
        FN_INC  = 4'd6,
        FN_ITOF = 4'd7,
        FN_FTOI = 4'd8
    } t_func;

    typedef struct packed {
        logic        valid;
        logic [3:0]  func;
        logic [31:0] res;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
        logic        neg;
    } t_side;

endpackage

@@ rtl/fpa_divider.sv @@
`timescale 1ns / 1ps
module fpa_divider #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [63:0] o_quo,
    output logic        o_valid
);
    import fpa_pkg::*;

    // Restoring division, one quotient bit per stage; the numerator never
    // exceeds 32 + FRAC_BITS bits, so that many stages suffice.
    localparam int NB = 32 + FRAC_BITS;

    logic [NB-1:0] r_num [NB+1];
    logic [NB-1:0] r_quo [NB+1];
    logic [32:0]   r_rem [NB+1];
    logic [31:0]   r_den [NB+1];
    logic          r_vld [NB+1];

    always_comb begin
        r_num[0] = i_num[NB-1:0];
        r_quo[0] = '0;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_vld[0] = i_valid;
    end

    for (genvar s = 0; s < NB; s++) begin : g_st
        logic [32:0] n_trial;
        logic [32:0] n_sh;
        always_comb begin
            n_sh    = {r_rem[s][31:0], r_num[s][NB-1-s]};
            n_trial = n_sh - {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                if (!n_trial[32]) begin
                    r_rem[s+1] <= n_trial;
                    r_quo[s+1] <= {r_quo[s][NB-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_sh;
                    r_quo[s+1] <= {r_quo[s][NB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo   = {{(64-NB){1'b0}}, r_quo[NB]};
    assign o_valid = r_vld[NB];
endmodule

@@ rtl/fixed_point_alu_core.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Ports        | Contents
// s_axis  | in        | s_axis_t*    | tuser: func; tdata: operand_a, operand_b
// m_axis  | out       | m_axis_t*    | tdata: result, a_less, a_equal, a_greater,
//         |           |              | divide_by_zero
//
// Every transaction passes through stage 1, the divider stages and the output
// register; the divider yields one quotient bit per stage. One transaction
// is accepted each cycle unless held. Reset is synchronous and active low and
// clears only the valid bits. The whole pipeline advances together; it holds
// when the output register is full and the consumer is not ready.
module fixed_point_alu_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bits 63:0: operand_a [31:0], operand_b [63:32]
    input  logic [63:0] s_axis_tdata,
    // bits 3:0: func
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result [31:0], a_less [32], a_equal [33], a_greater [34],
    // divide_by_zero [35], zeros [39:36]
    output logic [39:0] m_axis_tdata
);
    import fpa_pkg::*;

    localparam int NB  = 32 + FRAC_BITS;
    localparam int DLY = NB;

    logic        w_en;
    logic [31:0] w_a, w_b;
    logic [3:0]  w_f;

    // Everything moves when the output stage is empty or being drained.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_a = s_axis_tdata[31:0];
    assign w_b = s_axis_tdata[63:32];
    assign w_f = s_axis_tuser;

    // Stage 1: compares, simple operations, the multiplier and the divider operands.
    t_side        r_s1;
    logic [63:0]  r_prod;
    logic [63:0]  r_num;
    logic [31:0]  r_den;
    t_side        n_s1;
    logic [31:0]  w_ma, w_mb;

    always_comb begin
        n_s1       = '0;
        n_s1.valid = s_axis_tvalid;
        n_s1.func  = w_f;
        n_s1.lt    = $signed(w_a) < $signed(w_b);
        n_s1.gt    = $signed(w_a) > $signed(w_b);
        n_s1.eq    = w_a == w_b;
        n_s1.neg   = w_a[31] ^ w_b[31];
        w_ma       = w_a[31] ? 32'(-w_a) : w_a;
        w_mb       = w_b[31] ? 32'(-w_b) : w_b;
        case (w_f)
            FN_ADD:  n_s1.res = w_a + w_b;
            FN_SUB:  n_s1.res = w_a - w_b;
            FN_MIN:  n_s1.res = n_s1.lt ? w_a : w_b;
            FN_MAX:  n_s1.res = n_s1.gt ? w_a : w_b;
            FN_INC:  n_s1.res = w_a + 32'd1;
            FN_ITOF: n_s1.res = w_a << FRAC_BITS;
            FN_FTOI: n_s1.res = 32'($signed(w_a) >>> FRAC_BITS);
            FN_DIV:  n_s1.dz  = (w_b == '0);
            default: n_s1.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s1.valid <= n_s1.valid;
        end
        if (w_en) begin
            r_s1[$bits(t_side)-2:0] <= n_s1[$bits(t_side)-2:0];
            r_prod <= 64'($signed(w_a) * $signed(w_b));
            r_num  <= {32'd0, w_ma} << FRAC_BITS;
            r_den  <= w_mb;
        end
    end

    // Divider stages; the side band and the product travel alongside.
    logic [63:0] w_quo;
    logic        w_qv;

    fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1.valid),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_quo   (w_quo),
        .o_valid (w_qv)
    );

    t_side       r_sd [DLY];
    logic [31:0] r_pd [DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) r_sd[i].valid <= 1'b0;
        end else if (w_en) begin
            r_sd[0].valid <= r_s1.valid;
            for (int i = 1; i < DLY; i++) r_sd[i].valid <= r_sd[i-1].valid;
        end
        if (w_en) begin
            r_sd[0][$bits(t_side)-2:0] <= r_s1[$bits(t_side)-2:0];
            r_pd[0] <= 32'($signed(r_prod) >>> FRAC_BITS);
            for (int i = 1; i < DLY; i++) begin
                r_sd[i][$bits(t_side)-2:0] <= r_sd[i-1][$bits(t_side)-2:0];
                r_pd[i] <= r_pd[i-1];
            end
        end
    end

    // Final stage: sign the quotient and select the result.
    t_side       w_t;
    logic [31:0] n_res;
    logic [31:0] r_res;
    logic        r_lt, r_eq, r_gt, r_dz;

    always_comb begin
        w_t = r_sd[DLY-1];
        case (w_t.func)
            FN_MUL:  n_res = r_pd[DLY-1];
            FN_DIV:  n_res = w_t.dz ? 32'd0
                           : (w_t.neg ? 32'(-w_quo) : w_quo[31:0]);
            default: n_res = w_t.res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            m_axis_tvalid <= w_t.valid && w_qv;
        end
        if (w_en) begin
            r_res <= n_res;
            r_lt  <= w_t.lt;
            r_eq  <= w_t.eq;
            r_gt  <= w_t.gt;
            r_dz  <= w_t.dz;
        end
    end

    assign m_axis_tdata = {4'd0, r_dz, r_gt, r_eq, r_lt, r_res};
endmodule
